>>> rtl/core/sfd_pkg.sv
// shared types and constants for the spi frame dispatcher
// used by sfd_ctrl, sfd_datapath and the top level; no dependencies
package sfd_pkg;

  localparam int unsigned FrameBytesDef = 32;
  localparam int unsigned MaxPayload    = 30;
  localparam int unsigned FirstPayload  = 2;
  localparam int unsigned MinLen        = 3;

  localparam logic [31:0] IdleIntervalRst = 32'd50000;
  localparam logic [7:0]  JiggleKeyRst    = 8'h47;

  typedef enum logic [1:0] {
    CmdSpi    = 2'd0,
    CmdSelect = 2'd1,
    CmdTick   = 2'd2,
    CmdRsvd   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KindKbd     = 3'd0,
    KindMouse   = 3'd1,
    KindPress   = 3'd2,
    KindRelease = 3'd3,
    KindReply   = 3'd4
  } kind_e;

  typedef enum logic {
    CfgIdleInterval = 1'b0,
    CfgJiggleKey    = 1'b1
  } cfg_idx_e;

  // where the byte of an emitted result comes from
  typedef enum logic [1:0] {
    SrcKey  = 2'd0,
    SrcZero = 2'd1,
    SrcLed  = 2'd2,
    SrcMem  = 2'd3
  } src_e;

  typedef enum logic [2:0] {
    StIdle   = 3'd0,
    StJigChk = 3'd1,
    StJig    = 3'd2,
    StReply  = 3'd3,
    StHdr0   = 3'd4,
    StHdr1   = 3'd5,
    StType   = 3'd6,
    StPay    = 3'd7
  } state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic       first_of_transfer;
    logic       byte_present;
    logic [7:0] rx_byte;
    logic       select_level;
    logic [7:0] led_state;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic  accept;
    logic  clear_ms;
    logic  rd_start;
    logic  rd_next;
    logic  hdr_capture;
    logic  emit;
    kind_e kind;
    src_e  src;
    logic  last;
  } dp_cmd_t;

  typedef struct packed {
    logic sel_rise;
    logic sel_fall;
    logic sel_hold_high;
    logic tick;
    logic jig_due;
    logic hdr_ok;
    logic type_ok;
    logic type_mouse;
    logic slot_free;
    logic pay_end;
  } dp_status_t;

endpackage

>>> rtl/core/sfd_ctrl.sv
// controller state machine: sequences dispatch reads, jiggle and reply results
// depends on sfd_pkg; drives the datapath only through dp_cmd_t
module sfd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sfd_pkg::dp_status_t    st_i,
  output sfd_pkg::dp_cmd_t       cmd_o
);

  sfd_pkg::state_e state_q, state_d;
  logic [1:0]      jig_cnt_q, jig_cnt_d;
  sfd_pkg::kind_e  disp_kind_q, disp_kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfd_pkg::StIdle;
      jig_cnt_q   <= 2'd0;
      disp_kind_q <= sfd_pkg::KindKbd;
    end else begin
      state_q     <= state_d;
      jig_cnt_q   <= jig_cnt_d;
      disp_kind_q <= disp_kind_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    jig_cnt_d         = jig_cnt_q;
    disp_kind_d       = disp_kind_q;
    in_stall_o        = (state_q != sfd_pkg::StIdle);
    cmd_o             = '0;
    cmd_o.kind        = sfd_pkg::KindKbd;
    cmd_o.src         = sfd_pkg::SrcZero;
    case (state_q)
      sfd_pkg::StIdle: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (st_i.sel_rise) begin
            state_d = sfd_pkg::StHdr0;
          end else if (st_i.sel_hold_high || st_i.tick) begin
            state_d = sfd_pkg::StJigChk;
          end else if (st_i.sel_fall) begin
            state_d = sfd_pkg::StReply;
          end
        end
      end
      sfd_pkg::StJigChk: begin
        if (st_i.jig_due) begin
          cmd_o.clear_ms = 1'b1;
          state_d        = sfd_pkg::StJig;
        end else begin
          state_d = sfd_pkg::StIdle;
        end
      end
      sfd_pkg::StJig: begin
        // press, release, press, release
        cmd_o.emit = 1'b1;
        cmd_o.kind = jig_cnt_q[0] ? sfd_pkg::KindRelease : sfd_pkg::KindPress;
        cmd_o.src  = jig_cnt_q[0] ? sfd_pkg::SrcZero : sfd_pkg::SrcKey;
        cmd_o.last = (jig_cnt_q == 2'd3);
        if (st_i.slot_free) begin
          jig_cnt_d = jig_cnt_q + 2'd1;
          if (jig_cnt_q == 2'd3) begin
            state_d = sfd_pkg::StIdle;
          end
        end
      end
      sfd_pkg::StReply: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = sfd_pkg::KindReply;
        cmd_o.src  = sfd_pkg::SrcLed;
        cmd_o.last = 1'b1;
        if (st_i.slot_free) begin
          state_d = sfd_pkg::StIdle;
        end
      end
      sfd_pkg::StHdr0: begin
        cmd_o.rd_start = 1'b1;
        state_d        = sfd_pkg::StHdr1;
      end
      sfd_pkg::StHdr1: begin
        // length byte is on the read port now
        cmd_o.hdr_capture = 1'b1;
        cmd_o.rd_next     = 1'b1;
        state_d           = sfd_pkg::StType;
      end
      sfd_pkg::StType: begin
        if (st_i.hdr_ok && st_i.type_ok) begin
          disp_kind_d   = st_i.type_mouse ? sfd_pkg::KindMouse : sfd_pkg::KindKbd;
          cmd_o.rd_next = 1'b1;
          state_d       = sfd_pkg::StPay;
        end else begin
          state_d = sfd_pkg::StIdle;
        end
      end
      sfd_pkg::StPay: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = disp_kind_q;
        cmd_o.src  = sfd_pkg::SrcMem;
        cmd_o.last = st_i.pay_end;
        if (st_i.slot_free) begin
          if (st_i.pay_end) begin
            state_d = sfd_pkg::StIdle;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = sfd_pkg::StIdle;
      end
    endcase
  end

  a_jig_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sfd_pkg::StJig) |-> (jig_cnt_q == 2'd0))
    else $error("jiggle counter left nonzero outside the jiggle sequence");

  a_rise_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && st_i.sel_rise) |=> (state_q == sfd_pkg::StHdr0))
    else $error("select rise did not start a frame dispatch");

endmodule

>>> rtl/core/sfd_datapath.sv
// datapath: frame bank memory, offsets, select and millisecond state,
// config registers and the output register; depends on sfd_pkg
module sfd_datapath #(
  parameter int unsigned FrameBytes = sfd_pkg::FrameBytesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfd_pkg::in_item_t    in_item_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  sfd_pkg::dp_cmd_t     cmd_i,
  output sfd_pkg::dp_status_t  st_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sfd_pkg::out_item_t   out_item_o
);

  localparam int unsigned AddrW = $clog2(FrameBytes);
  localparam int unsigned LenW  = $clog2(FrameBytes + 1);
  localparam int unsigned Depth = 2 * (2 ** AddrW);
  localparam logic [7:0]  PayEnd = 8'(sfd_pkg::FirstPayload + sfd_pkg::MaxPayload);

  logic [LenW-1:0]  off_q, off_d, off_eff;
  logic             bank_q, bank_d;
  logic             prev_q, prev_d;
  logic [31:0]      ms_q, ms_d;
  logic [31:0]      idle_q;
  logic [7:0]       key_q;
  logic [LenW-1:0]  disp_len_q, disp_len_d;
  logic [7:0]       led_q, led_d;
  logic             hdr_ok_q, hdr_ok_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic             out_valid_q, out_valid_d;
  sfd_pkg::out_item_t out_q, out_d;

  logic [7:0]       mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [7:0]       rd_data_q;
  logic             rd_vld_q;
  logic [7:0]       rd_byte;
  logic             wr_en, rd_en, is_spi, is_sel, load;
  logic [AddrW:0]   wr_addr, rd_addr;
  logic [7:0]       len8, end8, idx_next8;

  assign is_spi  = (in_item_i.cmd == sfd_pkg::CmdSpi);
  assign is_sel  = (in_item_i.cmd == sfd_pkg::CmdSelect);
  assign off_eff = in_item_i.first_of_transfer ? '0 : off_q;
  assign wr_en   = cmd_i.accept && is_spi && in_item_i.byte_present
                   && (off_eff < LenW'(FrameBytes));
  assign wr_addr = {bank_q, off_eff[AddrW-1:0]};
  assign rd_en   = cmd_i.rd_start || cmd_i.rd_next;
  // dispatch reads the bank that was just closed
  assign rd_addr = {~bank_q, rd_idx_d};
  assign rd_byte = rd_vld_q ? rd_data_q : 8'h00;

  assign len8      = {{(8 - LenW){1'b0}}, disp_len_q};
  assign end8      = (len8 < PayEnd) ? len8 : PayEnd;
  assign idx_next8 = {{(8 - AddrW){1'b0}}, rd_idx_q} + 8'd1;

  always_comb begin
    st_o               = '0;
    st_o.sel_rise      = is_sel && in_item_i.select_level && !prev_q;
    st_o.sel_hold_high = is_sel && in_item_i.select_level && prev_q;
    st_o.sel_fall      = is_sel && !in_item_i.select_level && prev_q;
    st_o.tick          = (in_item_i.cmd == sfd_pkg::CmdTick);
    st_o.jig_due       = prev_q && (ms_q > idle_q);
    st_o.hdr_ok        = hdr_ok_q;
    st_o.type_ok       = (rd_byte == 8'd1) || (rd_byte == 8'd2);
    st_o.type_mouse    = (rd_byte == 8'd2);
    st_o.slot_free     = !out_valid_q || !out_stall_i;
    st_o.pay_end       = (idx_next8 == end8);
  end

  assign load = cmd_i.emit && st_o.slot_free;

  always_comb begin
    off_d      = off_q;
    bank_d     = bank_q;
    prev_d     = prev_q;
    ms_d       = ms_q;
    disp_len_d = disp_len_q;
    led_d      = led_q;
    hdr_ok_d   = hdr_ok_q;
    rd_idx_d   = rd_idx_q;
    if (cmd_i.accept) begin
      if (is_spi) begin
        off_d = wr_en ? (off_eff + LenW'(1)) : off_eff;
      end else if (st_o.sel_rise) begin
        // swap banks; the offset carries over
        bank_d     = ~bank_q;
        prev_d     = 1'b1;
        ms_d       = '0;
        disp_len_d = off_q;
      end else if (st_o.sel_fall) begin
        prev_d = 1'b0;
        led_d  = in_item_i.led_state;
      end else if (st_o.tick) begin
        ms_d = ms_q + 32'd1;
      end
    end
    if (cmd_i.clear_ms) begin
      ms_d = '0;
    end
    if (cmd_i.hdr_capture) begin
      hdr_ok_d = (disp_len_q > LenW'(sfd_pkg::MinLen))
                 && (disp_len_q <= LenW'(FrameBytes)) && (rd_byte == len8);
    end
    if (cmd_i.rd_start) begin
      rd_idx_d = '0;
    end else if (cmd_i.rd_next) begin
      rd_idx_d = rd_idx_q + AddrW'(1);
    end
  end

  always_comb begin
    out_d      = out_q;
    out_d.kind = cmd_i.kind;
    out_d.last = cmd_i.last;
    case (cmd_i.src)
      sfd_pkg::SrcKey:  out_d.out_byte = key_q;
      sfd_pkg::SrcZero: out_d.out_byte = 8'h00;
      sfd_pkg::SrcLed:  out_d.out_byte = led_q;
      sfd_pkg::SrcMem:  out_d.out_byte = rd_byte;
      default:          out_d.out_byte = 8'h00;
    endcase
    if (load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= '0;
      bank_q      <= 1'b0;
      prev_q      <= 1'b1;
      ms_q        <= '0;
      idle_q      <= sfd_pkg::IdleIntervalRst;
      key_q       <= sfd_pkg::JiggleKeyRst;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      off_q       <= off_d;
      bank_q      <= bank_d;
      prev_q      <= prev_d;
      ms_q        <= ms_d;
      out_valid_q <= out_valid_d;
      rd_idx_q    <= rd_idx_d;
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (sfd_pkg::cfg_idx_e'(cfg_index_i))
          sfd_pkg::CfgIdleInterval: idle_q <= cfg_data_i;
          sfd_pkg::CfgJiggleKey:    key_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    disp_len_q <= disp_len_d;
    led_q      <= led_d;
    hdr_ok_q   <= hdr_ok_d;
    if (load) begin
      out_q <= out_d;
    end
  end

  // frame bank memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= in_item_i.rx_byte;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_off_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q <= LenW'(FrameBytes))
    else $error("write offset ran past the bank size");

  a_rise_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && st_o.sel_rise) |=> (prev_q && (ms_q == 32'd0)))
    else $error("select rise did not clear the idle counter");

endmodule

>>> rtl/core/spi_frame_dispatch_with_idle_jiggle.sv
// spi frame receiver with two banks, frame dispatch and idle key jiggle
// top level; depends on sfd_pkg, sfd_ctrl and sfd_datapath
//
// usage: items come in on in_item_i with in_valid_i/in_stall_o, results
// leave on out_item_o with out_valid_o/out_stall_i; a transfer happens when
// valid is high and stall is low. cfg_valid_i/cfg_ready_o write the idle
// interval (index 0) or the jiggle key (index 1); ready is always high.
// sequence: an spi byte or quiet item is taken without stalling the input. a
// select fall moves the controller to the reply state, which stalls the
// input until the output register is free and loads the led byte into it
// as the reply result. a tick or high select sample passes through the
// jiggle check state and, when the jiggle is due, the jiggle state, which
// emits the four key results. a select rise reads the closed bank's length
// and type bytes through the registered memory read port, then emits the
// payload bytes, one byte per cycle while the output does not stall.
// the input stalls while a run of results is in progress; a stalled output
// simply holds the controller in place, nothing is dropped.
// reset clears offsets, bank select, idle counter and per-entry valid bits,
// so unwritten bank entries read as zero; no clearing pass is needed.
module spi_frame_dispatch_with_idle_jiggle #(
  parameter int unsigned FrameBytes = sfd_pkg::FrameBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sfd_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sfd_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  sfd_pkg::dp_cmd_t    dp_cmd;
  sfd_pkg::dp_status_t dp_st;

  assign cfg_ready_o = 1'b1;

  sfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (dp_st),
    .cmd_o      (dp_cmd)
  );

  sfd_datapath #(
    .FrameBytes (FrameBytes)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (dp_cmd),
    .st_o        (dp_st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
